### hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLKD(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/pps_pkg.sv
`default_nettype none

package pps_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int LEVEL_W         = 11;
    localparam int CMD_W           = 2;
    localparam int BANK_DEPTH_DEF  = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam logic [LEVEL_W-1:0] CAPACITY_RESET = 11'd1024;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    // Per-word result flags and levels, handed from control to output stage
    typedef struct packed {
        logic               pop;
        logic               refused;
        logic               empty;
        logic [LEVEL_W-1:0] write_level;
        logic [LEVEL_W-1:0] read_level;
    } pps_info_t;

endpackage

`default_nettype wire

### hdl/pps_ram.sv
`default_nettype none

module pps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hdl/pps_ctrl.sv
`default_nettype none

module pps_ctrl
    import pps_pkg::*;
#(
    parameter int BANK_DEPTH  = BANK_DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int RAM_AW      = $clog2(2 * BANK_DEPTH)
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [LEVEL_W-1:0]     cfg_data,
    input  wire logic                   accept,
    input  wire logic [CMD_W-1:0]       cmd,
    input  wire logic [SAMPLE_W-1:0]    sample_in,
    output logic                        mem_we,
    output logic      [RAM_AW-1:0]      mem_waddr,
    output logic      [SAMPLE_BITS-1:0] mem_wdata,
    output logic                        mem_re,
    output logic      [RAM_AW-1:0]      mem_raddr,
    output pps_info_t                   info
);

    localparam int CW = $clog2(BANK_DEPTH + 1);
    localparam int W  = (CW > LEVEL_W) ? CW : LEVEL_W;

    logic               bank_reg, bank_next;
    logic [CW-1:0]      wf_reg, wf_next;
    logic [CW-1:0]      rp_reg, rp_next;
    logic [CW-1:0]      rf_reg, rf_next;
    logic [LEVEL_W-1:0] capacity_reg;

    logic          swap;
    logic          rd_bank;
    logic [CW-1:0] rf_eff;
    logic [CW-1:0] rp_eff;

    // A drained read bank swaps roles before the pop
    assign swap    = (rp_reg >= rf_reg);
    assign rf_eff  = swap ? wf_reg : rf_reg;
    assign rp_eff  = swap ? '0 : rp_reg;
    assign rd_bank = swap ? bank_reg : ~bank_reg;

    assign mem_wdata = SAMPLE_BITS'($unsigned(sample_in));
    assign mem_waddr = (bank_reg ? RAM_AW'(BANK_DEPTH) : '0) + RAM_AW'(wf_reg);
    assign mem_raddr = (rd_bank ? RAM_AW'(BANK_DEPTH) : '0) + RAM_AW'(rp_eff);

    always_comb begin
        bank_next    = bank_reg;
        wf_next      = wf_reg;
        rp_next      = rp_reg;
        rf_next      = rf_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        info.pop     = 1'b0;
        info.refused = 1'b0;
        info.empty   = 1'b0;
        if (accept) begin
            unique case (cmd_t'(cmd))
                CMD_WRITE: begin
                    if (W'(wf_reg) < W'(capacity_reg) && wf_reg < CW'(BANK_DEPTH)) begin
                        mem_we  = 1'b1;
                        wf_next = wf_reg + 1'b1;
                    end else begin
                        info.refused = 1'b1;
                    end
                end
                CMD_READ: begin
                    bank_next = swap ? ~bank_reg : bank_reg;
                    rf_next   = rf_eff;
                    wf_next   = swap ? '0 : wf_reg;
                    if (rp_eff < rf_eff) begin
                        mem_re   = 1'b1;
                        info.pop = 1'b1;
                        rp_next  = rp_eff + 1'b1;
                    end else begin
                        info.empty = 1'b1;
                        rp_next    = rp_eff;
                    end
                end
                CMD_CLEAR: begin
                    wf_next = '0;
                    rp_next = '0;
                    rf_next = '0;
                end
                default: begin
                end
            endcase
        end
        info.write_level = LEVEL_W'(wf_next);
        info.read_level  = LEVEL_W'(rf_next - rp_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_reg     <= 1'b0;
            wf_reg       <= '0;
            rp_reg       <= '0;
            rf_reg       <= '0;
            capacity_reg <= CAPACITY_RESET;
        end else begin
            bank_reg <= bank_next;
            wf_reg   <= wf_next;
            rp_reg   <= rp_next;
            rf_reg   <= rf_next;
            if (cfg_we) begin
                capacity_reg <= cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/ping_pong_sample_buffer.sv
// A result word passes the pending register, then the output register that drives m_*.
// Throughput: one word per cycle while m_tready does not stall the output; each word does
// at most one store access (write on append, read on pop) on the sample RAM.
// Reset clears fills, read position, bank select and the output stage; capacity
// returns to 1024. The sample store is not cleared.
`default_nettype none

module ping_pong_sample_buffer
    import pps_pkg::*;
#(
    parameter int BANK_DEPTH  = BANK_DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [LEVEL_W-1:0] cfg_data,   // capacity
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [15:0]        s_tdata,    // [15:0] sample_in
    input  wire logic [1:0]         s_tuser,    // [1:0] cmd
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic      [39:0]        m_tdata,    // [15:0] sample_out, [26:16] write_level,
                                                // [37:27] read_level, [39:38] zero
    output logic      [1:0]         m_tuser     // [0] write_refused, [1] read_empty
);

    localparam int RAM_DEPTH = 2 * BANK_DEPTH;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    logic                   accept;
    logic                   mem_we;
    logic [RAM_AW-1:0]      mem_waddr;
    logic [SAMPLE_BITS-1:0] mem_wdata;
    logic                   mem_re;
    logic [RAM_AW-1:0]      mem_raddr;
    logic [SAMPLE_BITS-1:0] mem_rdata;
    pps_info_t              info;

    logic       pend_valid_reg;
    pps_info_t  pend_info_reg;
    logic       pend_adv;

    logic        m_tvalid_reg;
    logic [39:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;
    logic [SAMPLE_W-1:0] sample_out;

    assign cfg_ready = 1'b1;
    assign pend_adv  = pend_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready  = !pend_valid_reg || pend_adv;
    assign accept    = s_tvalid && s_tready;

    pps_ctrl #(
        .BANK_DEPTH  (BANK_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .RAM_AW      (RAM_AW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .cmd       (s_tuser),
        .sample_in (s_tdata),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .info      (info)
    );

    pps_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RAM_DEPTH),
        .AW    (RAM_AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // RAM read data holds while the pending word stalls (no new read issued)
    assign sample_out = pend_info_reg.pop ? SAMPLE_W'(mem_rdata) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (accept) begin
                pend_valid_reg <= 1'b1;
            end else if (pend_adv) begin
                pend_valid_reg <= 1'b0;
            end
            if (pend_adv) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_info_reg <= info;
        end
        if (pend_adv) begin
            m_tdata_reg <= {2'b00, pend_info_reg.read_level,
                            pend_info_reg.write_level, sample_out};
            m_tuser_reg <= {pend_info_reg.empty, pend_info_reg.refused};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

### hdl/pps_checker.sv
`default_nettype none
`include "assert_macros.svh"

module pps_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // Stalled result word holds its payload
    `ASSERT_CLKD(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")

    // A word never flags both a refused write and an empty read
    `ASSERT_CLKD(a_flags_excl, aclk, aresetn, m_tvalid |-> !(m_tuser[0] && m_tuser[1]), "both flags set")

    // Empty read: nothing popped and nothing left to read
    `ASSERT_CLKD(a_empty_zero, aclk, aresetn, m_tvalid && m_tuser[1] |-> m_tdata[15:0] == 16'd0 && m_tdata[37:27] == 11'd0, "empty read with data or level")

    // Refused write returns no sample
    `ASSERT_CLKD(a_refused_zero, aclk, aresetn, m_tvalid && m_tuser[0] |-> m_tdata[15:0] == 16'd0, "refused write with data")

    // Output stage empty right after reset
    `ASSERT_CLK(a_reset_idle, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind ping_pong_sample_buffer pps_checker u_pps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

### tb/ping_pong_sample_buffer_test.sv
`default_nettype none

module ping_pong_sample_buffer_test;
    import pps_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic                refused;
        logic                empty;
        logic [LEVEL_W-1:0]  write_level;
        logic [LEVEL_W-1:0]  read_level;
    } buffer_word_t;

    // Tracks both banks, predicts each result word and checks the output stream.
    class sample_buffer_scoreboard;
        localparam int DEPTH = pps_pkg::BANK_DEPTH_DEF;

        logic [15:0]  bank_mem [2*DEPTH];
        bit           write_bank;
        int unsigned  write_fill;
        int unsigned  read_pos;
        int unsigned  read_fill;
        int unsigned  capacity;
        buffer_word_t pending_words [$];
        int           errors;
        int           accepted;
        int           refusals;
        int           empties;
        int           pops;

        function void reset_state();
            write_bank = 1'b0;
            write_fill = 0;
            read_pos   = 0;
            read_fill  = 0;
            capacity   = 1024;
        endfunction

        function void set_capacity(logic [10:0] value);
            capacity = value;
        endfunction

        function int pending();
            return pending_words.size();
        endfunction

        function void note_input(logic [1:0] op, logic [15:0] smp);
            buffer_word_t w;
            int unsigned  cap_eff;
            w.sample  = '0;
            w.refused = 1'b0;
            w.empty   = 1'b0;
            cap_eff   = (capacity > DEPTH) ? DEPTH : capacity;
            accepted++;
            case (op)
                CMD_WRITE: begin
                    if (write_fill < cap_eff) begin
                        bank_mem[int'(write_bank) * DEPTH + write_fill] = smp;
                        write_fill++;
                    end else begin
                        w.refused = 1'b1;
                        refusals++;
                    end
                end
                CMD_READ: begin
                    // drained read bank: swap roles, even when both are empty
                    if (read_pos >= read_fill) begin
                        write_bank = ~write_bank;
                        read_fill  = write_fill;
                        read_pos   = 0;
                        write_fill = 0;
                    end
                    if (read_pos < read_fill) begin
                        w.sample = bank_mem[(write_bank ? 0 : DEPTH) + read_pos];
                        read_pos++;
                        pops++;
                    end else begin
                        w.empty = 1'b1;
                        empties++;
                    end
                end
                CMD_CLEAR: begin
                    write_fill = 0;
                    read_pos   = 0;
                    read_fill  = 0;
                end
                default: ;
            endcase
            w.write_level = write_fill[LEVEL_W-1:0];
            w.read_level  = 11'(read_fill - read_pos);
            pending_words.push_back(w);
        endfunction

        task report_mismatch(string what, logic [39:0] got, logic [39:0] want);
            $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
            errors++;
        endtask

        task check_result(logic [39:0] data, logic [1:0] user);
            buffer_word_t w;
            if (pending_words.size() == 0) begin
                report_mismatch("word with nothing outstanding", data, '0);
                return;
            end
            w = pending_words.pop_front();
            if (data[15:0] !== w.sample)
                report_mismatch("sample_out", data[15:0], w.sample);
            if (data[26:16] !== w.write_level)
                report_mismatch("write_level", data[26:16], w.write_level);
            if (data[37:27] !== w.read_level)
                report_mismatch("read_level", data[37:27], w.read_level);
            if (data[39:38] !== 2'b00)
                report_mismatch("tdata pad bits", data[39:38], 2'b00);
            if (user[0] !== w.refused)
                report_mismatch("write_refused", user[0], w.refused);
            if (user[1] !== w.empty)
                report_mismatch("read_empty", user[1], w.empty);
        endtask
    endclass

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [LEVEL_W-1:0] cfg_data  = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [15:0]        s_tdata   = '0;
    logic [1:0]         s_tuser   = '0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [39:0]        m_tdata;
    logic [1:0]         m_tuser;

    int gap_pct   = 0;
    int stall_pct = 0;
    int settings  = 0;

    sample_buffer_scoreboard sb;

    ping_pong_sample_buffer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    task automatic send_word(input logic [1:0] op, input logic [15:0] smp);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= smp;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(op, smp);
    endtask

    // Waits until the buffer has drained, so the new setting applies cleanly.
    task automatic write_capacity(input logic [LEVEL_W-1:0] value);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_capacity(value);
        settings++;
    endtask

    task automatic random_phase(input logic [LEVEL_W-1:0] cap, input int mode, input int count);
        int sent;
        int nw;
        int nr;
        int r;
        int span;
        write_capacity(cap);
        gap_pct   = (mode == 1) ? 51 : (mode == 3) ? 31 : 0;
        stall_pct = (mode == 2) ? 51 : (mode == 3) ? 31 : 0;
        span = (cap > 40) ? 40 : int'(cap);
        sent = 0;
        while (sent < count) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
                // write burst of up to the capacity (at most 40) plus two, then up to two reads more than written
                nw = $urandom_range(1, span + 2);
                nr = $urandom_range(1, nw + 2);
                repeat (nw) send_word(CMD_WRITE, 16'($urandom));
                repeat (nr) send_word(CMD_READ, 16'($urandom));
                sent += nw + nr;
            end else if (r < 87) begin
                send_word(CMD_CLEAR, 16'($urandom));
                sent++;
            end else if (r < 93) begin
                send_word(CMD_UNUSED, 16'($urandom));
                sent++;
            end else begin
                send_word(2'($urandom_range(0, 3)), 16'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        #2000000;
        $display("ping_pong_sample_buffer test failed");
        $finish;
    end

    initial begin
        logic [LEVEL_W-1:0] caps [10];
        sb = new();
        sb.reset_state();
        caps = '{11'd5, 11'd1, 11'd2047, 11'd16, 11'd0, 11'd1024, 11'd3, 11'd64, 11'd2, 11'd700};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: default capacity, empty swaps, sample extremes, unused opcode
        send_word(CMD_READ,   16'h1234);
        send_word(CMD_WRITE,  16'h7FFF);
        send_word(CMD_WRITE,  16'h8000);
        send_word(CMD_UNUSED, 16'hFFFF);
        send_word(CMD_READ,   16'h0000);
        send_word(CMD_WRITE,  16'h0000);
        send_word(CMD_READ,   16'h0000);
        send_word(CMD_READ,   16'h0000);
        send_word(CMD_READ,   16'h0000);
        send_word(CMD_WRITE,  16'hFFFF);
        send_word(CMD_CLEAR,  16'h5555);
        send_word(CMD_READ,   16'h0000);

        // full write bank, then capacity lowered under the current fill
        write_capacity(11'd3);
        send_word(CMD_WRITE, 16'hFFFF);
        send_word(CMD_WRITE, 16'h5555);
        send_word(CMD_WRITE, 16'hAAAA);
        send_word(CMD_WRITE, 16'h0001);
        send_word(CMD_READ,  16'h0000);
        send_word(CMD_WRITE, 16'h8001);
        send_word(CMD_WRITE, 16'h7FFE);
        write_capacity(11'd1);
        send_word(CMD_WRITE, 16'h4321);
        send_word(CMD_READ,  16'h0000);
        send_word(CMD_READ,  16'h0000);
        send_word(CMD_READ,  16'h0000);
        write_capacity(11'd0);
        send_word(CMD_WRITE, 16'h2468);

        for (int i = 0; i < 10; i++)
            random_phase(caps[i], i % 4, 92);

        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("ran %0d words across %0d capacity writes, idle and stall mixes included",
                 sb.accepted, settings);
        $display("saw %0d pops, %0d refused writes, %0d reads with both banks empty",
                 sb.pops, sb.refusals, sb.empties);
        if (sb.errors == 0) begin
            $display("ping_pong_sample_buffer test passed");
        end else begin
            $display("ping_pong_sample_buffer test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
